// ===== src/qbpg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qbpg_pkg: shared types and constants of the quadratic Bezier point generator
// Coordinate and count widths, and the parameter defaults of the top level.
// ----------------------------------------------------------------------------
package qbpg_pkg;

    localparam int COORD_W          = 32;
    localparam int SEG_W            = 6;
    localparam int DEF_MAX_SEGMENTS = 63;
    localparam int DEF_FRAC_BITS    = 16;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [SEG_W-1:0]          seg_t;

endpackage : qbpg_pkg
`default_nettype wire

// ===== src/qbpg_curve_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qbpg_curve_if: request channel of the point generator
// Carries start, control and end point and the segment count.
// ----------------------------------------------------------------------------
interface qbpg_curve_if
    import qbpg_pkg::*;
;
    logic   valid;
    logic   ready;
    coord_t start_x;
    coord_t start_y;
    coord_t start_z;
    coord_t ctrl_x;
    coord_t ctrl_y;
    coord_t ctrl_z;
    coord_t end_x;
    coord_t end_y;
    coord_t end_z;
    seg_t   segment_count;

    modport source (
        output valid, start_x, start_y, start_z, ctrl_x, ctrl_y, ctrl_z,
               end_x, end_y, end_z, segment_count,
        input  ready
    );

    modport sink (
        input  valid, start_x, start_y, start_z, ctrl_x, ctrl_y, ctrl_z,
               end_x, end_y, end_z, segment_count,
        output ready
    );

endinterface : qbpg_curve_if
`default_nettype wire

// ===== src/qbpg_point_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qbpg_point_if: result channel of the point generator
// Carries one curve point and the flag that marks the end point.
// ----------------------------------------------------------------------------
interface qbpg_point_if
    import qbpg_pkg::*;
;
    logic   valid;
    logic   ready;
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
    logic   last_point;

    modport source (
        output valid, point_x, point_y, point_z, last_point,
        input  ready
    );

    modport sink (
        input  valid, point_x, point_y, point_z, last_point,
        output ready
    );

endinterface : qbpg_point_if
`default_nettype wire

// ===== src/qbpg_tdiv.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qbpg_tdiv: bit-serial divider for the curve parameter
// Forms t = floor(i * 2^FRAC_BITS / n) for i < n, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module qbpg_tdiv
    import qbpg_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire seg_t                 dividend,
    input  wire seg_t                 divisor,
    output logic                      done,
    output logic [FRAC_BITS-1:0]      quot
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    seg_t                 rem_reg;
    seg_t                 rem_next;
    logic [FRAC_BITS-1:0] quot_reg;
    logic [FRAC_BITS-1:0] quot_next;
    logic [SEG_W:0]       shifted;
    logic [SEG_W:0]       trial;
    logic                 fits;

    // remainder stays below the divisor, so doubling needs one extra bit
    assign shifted = {rem_reg, 1'b0};
    assign trial   = shifted - {1'b0, divisor};
    assign fits    = (shifted >= {1'b0, divisor});

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (start)
        begin
            cnt_next  = CNT_W'(FRAC_BITS);
            busy_next = 1'b1;
            rem_next  = dividend;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? trial[SEG_W-1:0] : shifted[SEG_W-1:0];
            quot_next = {quot_reg[FRAC_BITS-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule : qbpg_tdiv
`default_nettype wire

// ===== src/qbpg_lerp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qbpg_lerp: shared linear interpolation unit
// Computes p + floor((q - p) * t / 2^FRAC_BITS), wrapped to 32 bits, in
// three steps: difference, multiply, shift and add.
// ----------------------------------------------------------------------------
module qbpg_lerp
    import qbpg_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire coord_t               p,
    input  wire coord_t               q,
    input  wire logic [FRAC_BITS-1:0] t,
    output logic                      done,
    output coord_t                    result
);

    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = DIFF_W + FRAC_BITS + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD
    } lerp_state_t;

    lerp_state_t              state_reg;
    lerp_state_t              state_next;
    logic                     done_reg;
    logic                     done_next;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [PROD_W-1:0] prod_reg;
    coord_t                   p_reg;
    logic [FRAC_BITS-1:0]     t_reg;
    coord_t                   result_reg;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            diff_reg <= $signed({q[COORD_W-1], q}) - $signed({p[COORD_W-1], p});
            p_reg    <= p;
            t_reg    <= t;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= diff_reg * $signed({1'b0, t_reg});
        end
        // arithmetic shift right floors; keep the low word only
        if (state_reg == ST_ADD)
        begin
            result_reg <= p_reg + prod_reg[FRAC_BITS+COORD_W-1:FRAC_BITS];
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule : qbpg_lerp
`default_nettype wire

// ===== src/quadratic_bezier_point_generator.sv =====
// A zero-count request goes straight to loading out its end point; otherwise the first point
// is offered once the divider has formed t and the interpolations for it are done.
// For each sampled point the bit-serial divider forms t, then nine interpolations run on the
// one shared lerp unit, and then the point is loaded out.
// A request holds the request side off until its end point is loaded out, and longer while a
// point waits on the result side. Reset (rst_n, asynchronous, active low) returns to idle.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_bezier_point_generator: de Casteljau point generator, top level
// Samples a 3-D quadratic Bezier curve at N points and then emits its end point.
// ----------------------------------------------------------------------------
module quadratic_bezier_point_generator
    import qbpg_pkg::*;
#(
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
    parameter int FRAC_BITS    = DEF_FRAC_BITS
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    qbpg_curve_if.sink    curve,
    qbpg_point_if.source  point
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_LERP_GO,
        S_LERP_WAIT,
        S_PUT,
        S_PUT_END
    } seq_state_t;

    typedef enum logic [1:0] {
        LERP_A,
        LERP_B,
        LERP_R
    } lerp_sel_t;

    seq_state_t           state_reg;
    seq_state_t           state_next;
    lerp_sel_t            sel_reg;
    lerp_sel_t            sel_next;
    logic [1:0]           coord_reg;
    logic [1:0]           coord_next;
    seg_t                 n_reg;
    seg_t                 n_next;
    seg_t                 i_reg;
    seg_t                 i_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    coord_t               s_reg [3];
    coord_t               c_reg [3];
    coord_t               e_reg [3];
    coord_t               a_reg;
    coord_t               b_reg;
    coord_t               res_reg [3];
    coord_t               px_reg;
    coord_t               py_reg;
    coord_t               pz_reg;
    logic                 last_reg;

    logic                 accept;
    logic                 load_out;
    seg_t                 n_sat;
    logic                 div_start;
    logic                 div_done;
    logic [FRAC_BITS-1:0] t_val;
    logic                 lerp_start;
    logic                 lerp_done;
    coord_t               lerp_p;
    coord_t               lerp_q;
    coord_t               lerp_res;

    assign accept     = curve.valid && (state_reg == S_IDLE);
    assign load_out   = ((state_reg == S_PUT) || (state_reg == S_PUT_END)) &&
                        (!out_valid_reg || point.ready);
    assign n_sat      = (curve.segment_count > SEG_W'(MAX_SEGMENTS)) ?
                        SEG_W'(MAX_SEGMENTS) : curve.segment_count;
    assign div_start  = (state_reg == S_DIV_GO);
    assign lerp_start = (state_reg == S_LERP_GO);

    qbpg_tdiv #(
        .FRAC_BITS (FRAC_BITS)
    ) u_tdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (i_reg),
        .divisor  (n_reg),
        .done     (div_done),
        .quot     (t_val)
    );

    always_comb
    begin
        case (sel_reg)
            LERP_A:
            begin
                lerp_p = s_reg[coord_reg];
                lerp_q = c_reg[coord_reg];
            end
            LERP_B:
            begin
                lerp_p = c_reg[coord_reg];
                lerp_q = e_reg[coord_reg];
            end
            default:
            begin
                lerp_p = a_reg;
                lerp_q = b_reg;
            end
        endcase
    end

    qbpg_lerp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lerp (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (lerp_start),
        .p      (lerp_p),
        .q      (lerp_q),
        .t      (t_val),
        .done   (lerp_done),
        .result (lerp_res)
    );

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        coord_next = coord_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    n_next     = n_sat;
                    i_next     = '0;
                    state_next = (n_sat == '0) ? S_PUT_END : S_DIV_GO;
                end
            end
            S_DIV_GO:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    coord_next = '0;
                    sel_next   = LERP_A;
                    state_next = S_LERP_GO;
                end
            end
            S_LERP_GO:
            begin
                state_next = S_LERP_WAIT;
            end
            S_LERP_WAIT:
            begin
                if (lerp_done)
                begin
                    state_next = S_LERP_GO;
                    case (sel_reg)
                        LERP_A:
                        begin
                            sel_next = LERP_B;
                        end
                        LERP_B:
                        begin
                            sel_next = LERP_R;
                        end
                        default:
                        begin
                            sel_next = LERP_A;
                            if (coord_reg == 2'd2)
                            begin
                                state_next = S_PUT;
                            end
                            else
                            begin
                                coord_next = coord_reg + 2'd1;
                            end
                        end
                    endcase
                end
            end
            S_PUT:
            begin
                if (load_out)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ((i_reg + 1'b1) == n_reg) ? S_PUT_END : S_DIV_GO;
                end
            end
            S_PUT_END:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (point.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= LERP_A;
            coord_reg     <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            coord_reg     <= coord_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_reg[0] <= curve.start_x;
            s_reg[1] <= curve.start_y;
            s_reg[2] <= curve.start_z;
            c_reg[0] <= curve.ctrl_x;
            c_reg[1] <= curve.ctrl_y;
            c_reg[2] <= curve.ctrl_z;
            e_reg[0] <= curve.end_x;
            e_reg[1] <= curve.end_y;
            e_reg[2] <= curve.end_z;
        end
        if (state_reg == S_LERP_WAIT && lerp_done)
        begin
            case (sel_reg)
                LERP_A:
                begin
                    a_reg <= lerp_res;
                end
                LERP_B:
                begin
                    b_reg <= lerp_res;
                end
                default:
                begin
                    res_reg[coord_reg] <= lerp_res;
                end
            endcase
        end
        // the end point is passed through untouched
        if (load_out)
        begin
            if (state_reg == S_PUT)
            begin
                px_reg   <= res_reg[0];
                py_reg   <= res_reg[1];
                pz_reg   <= res_reg[2];
                last_reg <= 1'b0;
            end
            else
            begin
                px_reg   <= e_reg[0];
                py_reg   <= e_reg[1];
                pz_reg   <= e_reg[2];
                last_reg <= 1'b1;
            end
        end
    end

    assign curve.ready      = (state_reg == S_IDLE);
    assign point.valid      = out_valid_reg;
    assign point.point_x    = px_reg;
    assign point.point_y    = py_reg;
    assign point.point_z    = pz_reg;
    assign point.last_point = last_reg;

endmodule : quadratic_bezier_point_generator
`default_nettype wire
